[rtl/core/psc_pkg.sv]
// ----------------------------------------------------------------------------
// psc_pkg: shared types and constants of the PRNG stream checker
// Word layouts, status codes and generator constants.
// ----------------------------------------------------------------------------
package psc_pkg;

  localparam int unsigned NumSourcesDefault = 4;
  localparam int unsigned CfgAddrW          = 3;

  localparam logic [7:0]  MarkStart = 8'd83;

  localparam logic [31:0] LcgMulMs   = 32'd214013;
  localparam logic [31:0] LcgIncMs   = 32'd2531011;
  localparam logic [31:0] LcgMulAnsi = 32'd1103515245;
  localparam logic [31:0] LcgIncAnsi = 32'd12345;

  // register indexes on the configuration port
  localparam logic RegLcgMode     = 1'b0;
  localparam logic RegInitialSeed = 1'b1;

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StBadRandom = 3'd1,
    StBadSeed   = 3'd2,
    StMissing   = 3'd3,
    StBadSource = 3'd4,
    StBadMarker = 3'd5
  } status_e;

  typedef struct packed {
    logic [7:0]  marker;
    logic [7:0]  source_id;
    logic [31:0] sequence_number;
    logic [31:0] seed_value;
    logic [31:0] random_value;
  } in_word_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] missing_count;
  } out_word_t;

  // per-source reference state
  typedef struct packed {
    logic [31:0] count;
    logic [31:0] seed;
  } entry_t;

endpackage

[rtl/core/prng_stream_checker.sv]
// ----------------------------------------------------------------------------
// prng_stream_checker: per-source LCG test pattern checker
//
//   channel   direction  handshake             payload
//   in        input      in_valid_i/in_ready_o  in_word_i  (in_word_t)
//   out       output     out_valid_o/out_ready_i out_word_o (out_word_t)
//   cfg       input      psel/penable/pwrite    paddr, pwdata, prdata
//
// One word per cycle while results are taken; a word passes the check stage,
// then the result register. The state RAM is read at accept and written as the
// word leaves, so a same-source word right behind uses a forwarding register.
// Reset, or a write of initial_seed, clears one valid bit per source; an
// invalid source reads as count zero and the current initial seed.
// A stalled result holds the check stage; input stalls only when both fill.
// ----------------------------------------------------------------------------
module prng_stream_checker #(
  parameter int unsigned NUM_SOURCES = psc_pkg::NumSourcesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  psc_pkg::in_word_t             in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output psc_pkg::out_word_t            out_word_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [psc_pkg::CfgAddrW-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import psc_pkg::*;

  localparam int unsigned IdxW = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

  logic                   lcg_mode_q;
  logic [31:0]            init_seed_q;
  logic                   cfg_wr;

  logic                   s1_valid_q;
  in_word_t               s1_word_q;
  logic                   fwd_q;
  entry_t                 fwd_entry_q;
  logic [NUM_SOURCES-1:0] entry_vld_q;
  logic                   out_valid_q;
  out_word_t              out_word_q;

  logic                   s1_adv;
  logic                   accept;
  logic [7:0]             rd_src;
  logic [7:0]             wr_src;
  logic [IdxW-1:0]        rd_idx;
  logic [IdxW-1:0]        wr_idx;
  entry_t                 ram_entry;
  entry_t                 cur_entry;
  entry_t                 new_entry;
  out_word_t              chk_result;
  logic                   chk_wr;
  logic                   wr_en;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == RegInitialSeed) ? init_seed_q : {31'd0, lcg_mode_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcg_mode_q  <= 1'b0;
      init_seed_q <= 32'd0;
    end else if (cfg_wr) begin
      if (paddr[2] == RegLcgMode) begin
        lcg_mode_q <= pwdata[0];
      end else begin
        init_seed_q <= pwdata;
      end
    end
  end

  // handshake
  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign accept     = in_valid_i && in_ready_o;

  assign rd_src = in_word_i.source_id - 8'd1;
  assign wr_src = s1_word_q.source_id - 8'd1;
  assign rd_idx = rd_src[IdxW-1:0];
  assign wr_idx = wr_src[IdxW-1:0];
  assign wr_en  = s1_valid_q && s1_adv && chk_wr;

  psc_ram #(
    .Width ($bits(entry_t)),
    .Depth (NUM_SOURCES)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_idx),
    .wdata_i (new_entry),
    .re_i    (accept),
    .raddr_i (rd_idx),
    .rdata_o (ram_entry)
  );

  always_comb begin
    if (fwd_q) begin
      cur_entry = fwd_entry_q;
    end else if (entry_vld_q[wr_idx]) begin
      cur_entry = ram_entry;
    end else begin
      cur_entry.count = 32'd0;
      cur_entry.seed  = init_seed_q;
    end
  end

  psc_check #(
    .NUM_SOURCES (NUM_SOURCES)
  ) u_check (
    .word_i     (s1_word_q),
    .entry_i    (cur_entry),
    .lcg_mode_i (lcg_mode_q),
    .result_o   (chk_result),
    .entry_o    (new_entry),
    .wr_o       (chk_wr)
  );

  // check stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (accept) begin
        // bypass the RAM when the word ahead writes the same source now
        fwd_q <= wr_en && (wr_idx == rd_idx);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_word_q   <= in_word_i;
      fwd_entry_q <= new_entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_vld_q <= '0;
    end else if (cfg_wr && (paddr[2] == RegInitialSeed)) begin
      entry_vld_q <= '0;
    end else if (wr_en) begin
      entry_vld_q[wr_idx] <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      out_word_q <= chk_result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // assertions
  a_no_accept_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("word accepted while both stages are held");

  a_seed_write_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_wr && (paddr[2] == RegInitialSeed)) |=> (entry_vld_q == '0))
    else $error("source state not cleared by seed write");

  a_write_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && !cfg_wr) |=> entry_vld_q[$past(wr_idx)])
    else $error("written source not marked valid");

  a_fwd_from_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(fwd_q) |-> $past(wr_en && accept))
    else $error("forwarding set without a concurrent write");

endmodule

[rtl/core/psc_ram.sv]
// ----------------------------------------------------------------------------
// psc_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module psc_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 4,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/psc_check.sv]
// ----------------------------------------------------------------------------
// psc_check: per-word check against the reference generator
// Steps one source's count and LCG, compares and picks the resync state.
// ----------------------------------------------------------------------------
module psc_check #(
  parameter int unsigned NUM_SOURCES = 4
) (
  input  psc_pkg::in_word_t  word_i,
  input  psc_pkg::entry_t    entry_i,
  input  logic               lcg_mode_i,
  output psc_pkg::out_word_t result_o,
  output psc_pkg::entry_t    entry_o,
  output logic               wr_o
);
  import psc_pkg::*;

  logic        good_src;
  logic [31:0] cnt;
  logic [31:0] mul;
  logic [31:0] inc;
  logic [31:0] ns;
  logic [31:0] val;

  assign good_src = (word_i.source_id != 8'd0) &&
                    ({1'b0, word_i.source_id} <= 9'(NUM_SOURCES));
  assign cnt = entry_i.count + 32'd1;
  assign mul = lcg_mode_i ? LcgMulAnsi : LcgMulMs;
  assign inc = lcg_mode_i ? LcgIncAnsi : LcgIncMs;
  assign ns  = 32'(entry_i.seed * mul) + inc;
  assign val = {17'd0, ns[30:16]};

  always_comb begin
    result_o.status        = StOk;
    result_o.missing_count = 32'd0;
    entry_o.count          = cnt;
    entry_o.seed           = ns;
    wr_o                   = 1'b0;
    if (word_i.marker != MarkStart) begin
      result_o.status = StBadMarker;
    end else if (!good_src) begin
      result_o.status = StBadSource;
    end else begin
      wr_o = 1'b1;
      if (cnt != word_i.sequence_number) begin
        // resync both count and seed
        result_o.status        = StMissing;
        result_o.missing_count = word_i.sequence_number - cnt;
        entry_o.count          = word_i.sequence_number;
        entry_o.seed           = word_i.seed_value;
      end else if (ns != word_i.seed_value) begin
        result_o.status = StBadSeed;
        entry_o.seed    = word_i.seed_value;
      end else if (val != word_i.random_value) begin
        result_o.status = StBadRandom;
      end
    end
  end

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for prng_stream_checker
// Sends test words from four simulated sources, mostly well-formed streams
// with injected faults, and scores every returned status word against an
// in-bench model of the per-source generators. Generator mode and seed are
// reprogrammed between phases over the register port.
// ----------------------------------------------------------------------------
module tb_top;
  import psc_pkg::*;

  localparam int unsigned NSRC = NumSourcesDefault;

  // two copies of the per-source table: one scores accepted words, one builds stimulus
  localparam int unsigned TblScore = 0;
  localparam int unsigned TblBuild = 1;

  typedef enum int {
    WkGood, WkBadRandom, WkBadSeed, WkSkip, WkBadSource, WkBadMarker
  } word_kind_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready_o;
  in_word_t in_word = '0;
  logic out_valid_o;
  logic out_ready = 1'b0;
  out_word_t out_word_o;

  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  prng_stream_checker #(.NUM_SOURCES(NSRC)) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_word_o  (out_word_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  logic cfg_mode = 1'b0;
  logic [31:0] cfg_seed = '0;
  entry_t src_tbl [2][1:NSRC];

  in_word_t tx_words[$];
  out_word_t verdict_q[$];

  int gap_pct = 0;
  int stall_pct = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_run = 0;
  int errors = 0;
  int n_results = 0;
  int n_settings = 1;
  int status_seen [6];

  function automatic logic [31:0] lcg_step(logic [31:0] s);
    if (cfg_mode) begin
      return s * LcgMulAnsi + LcgIncAnsi;
    end
    return s * LcgMulMs + LcgIncMs;
  endfunction

  // score one word against a source table and advance that table
  function automatic out_word_t score_word(in_word_t w, int unsigned tbl);
    out_word_t r;
    logic [31:0] cnt;
    logic [31:0] ns;
    int unsigned k;
    r.status = StOk;
    r.missing_count = '0;
    if (w.marker != MarkStart) begin
      r.status = StBadMarker;
    end else if (w.source_id == 8'd0 || w.source_id > NSRC) begin
      r.status = StBadSource;
    end else begin
      k = {24'd0, w.source_id};
      cnt = src_tbl[tbl][k].count + 32'd1;
      ns = lcg_step(src_tbl[tbl][k].seed);
      src_tbl[tbl][k].count = cnt;
      src_tbl[tbl][k].seed = ns;
      if (cnt != w.sequence_number) begin
        r.status = StMissing;
        r.missing_count = w.sequence_number - cnt;
        src_tbl[tbl][k].count = w.sequence_number;
        src_tbl[tbl][k].seed = w.seed_value;
      end else if (ns != w.seed_value) begin
        r.status = StBadSeed;
        src_tbl[tbl][k].seed = w.seed_value;
      end else if ({17'd0, ns[30:16]} != w.random_value) begin
        r.status = StBadRandom;
      end
    end
    return r;
  endfunction

  function automatic void restart_tables(logic [31:0] seed);
    for (int t = 0; t < 2; t++) begin
      for (int k = 1; k <= NSRC; k++) begin
        src_tbl[t][k].count = '0;
        src_tbl[t][k].seed = seed;
      end
    end
  endfunction

  // build a word for a source from the stimulus table, with the fault of the given kind
  function automatic in_word_t make_word(word_kind_e kind, int unsigned src);
    in_word_t w;
    logic [31:0] ns;
    w.marker = MarkStart;
    w.source_id = src[7:0];
    w.sequence_number = src_tbl[TblBuild][src].count + 32'd1;
    ns = lcg_step(src_tbl[TblBuild][src].seed);
    w.seed_value = ns;
    w.random_value = {17'd0, ns[30:16]};
    case (kind)
      WkBadRandom: begin
        if ($urandom_range(0, 1) == 0) begin
          w.random_value = $urandom();
        end else begin
          w.random_value = w.random_value ^ (32'd1 << $urandom_range(0, 14));
        end
      end
      WkBadSeed: begin
        w.seed_value = ($urandom_range(0, 1) == 0) ? $urandom()
                                                   : ns ^ (32'd1 << $urandom_range(0, 31));
      end
      WkSkip: begin
        if ($urandom_range(0, 1) == 0) begin
          w.sequence_number = w.sequence_number + $urandom_range(1, 3);
        end else begin
          w.sequence_number = $urandom();
        end
        if ($urandom_range(0, 1) == 0) begin
          w.seed_value = $urandom();
        end
      end
      WkBadSource: begin
        w = {$urandom(), $urandom(), $urandom(), 16'($urandom())};
        w.marker = MarkStart;
        w.source_id = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(NSRC + 1, 255));
      end
      WkBadMarker: begin
        w = {$urandom(), $urandom(), $urandom(), 16'($urandom())};
        if (w.marker == MarkStart) begin
          w.marker = w.marker ^ 8'($urandom_range(1, 255));
        end
      end
      default: ;
    endcase
    return w;
  endfunction

  function automatic void queue_word(in_word_t w);
    void'(score_word(w, TblBuild));
    tx_words.push_back(w);
  endfunction

  // sender: bursts of random length separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_word <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!in_valid || in_ready_o) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (tx_words.size() != 0) begin
        in_valid <= 1'b1;
        in_word <= tx_words.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 16);
          gap_left <= ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 8) : 0;
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: ready held at a random level for runs of random length
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      stall_run <= 0;
    end else if (stall_run != 0) begin
      stall_run <= stall_run - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
      stall_run <= $urandom_range(0, 11);
    end
  end

  // monitor: check the result word first, then score the word accepted at this edge
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready) begin
        n_results++;
        if (verdict_q.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected result at %0t: status %0d missing %h",
                     $time, out_word_o.status, out_word_o.missing_count);
          end
        end else begin
          want = verdict_q.pop_front();
          status_seen[want.status]++;
          if (out_word_o.status !== want.status ||
              out_word_o.missing_count !== want.missing_count) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch at %0t: expected status %0d missing %h, got status %0d missing %h",
                       $time, want.status, want.missing_count,
                       out_word_o.status, out_word_o.missing_count);
            end
          end
        end
      end
      if (in_valid && in_ready_o) begin
        verdict_q.push_back(score_word(in_word, TblScore));
      end
    end
  end

  task automatic write_reg(logic idx, logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == RegLcgMode) begin
      cfg_mode = data[0];
    end else begin
      cfg_seed = data;
      restart_tables(data);
    end
    n_settings++;
  endtask

  // wait until every queued word is sent and every result has come back, or the limit runs out
  task automatic drain(int limit);
    int n;
    n = 0;
    while ((tx_words.size() != 0 || in_valid || verdict_q.size() != 0) && n < limit) begin
      @(negedge clk_i);
      n++;
    end
  endtask

  task automatic run_phase(int n, int gp, int sp);
    word_kind_e kind;
    int r;
    gap_pct = gp;
    stall_pct = sp;
    @(negedge clk_i);
    repeat (n) begin
      r = $urandom_range(0, 99);
      kind = (r < 60) ? WkGood : (r < 70) ? WkBadRandom : (r < 78) ? WkBadSeed :
             (r < 86) ? WkSkip : (r < 93) ? WkBadSource : WkBadMarker;
      queue_word(make_word(kind, $urandom_range(1, NSRC)));
    end
    drain(20000);
  endtask

  initial begin
    in_word_t w;
    restart_tables(cfg_seed);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed words under the reset settings
    gap_pct = 30;
    stall_pct = 30;
    @(negedge clk_i);
    for (int k = 1; k <= NSRC; k++) begin
      queue_word(make_word(WkGood, k));
    end
    w = make_word(WkGood, 1);
    w.marker = 8'd0;
    queue_word(w);
    w.marker = 8'hff;
    queue_word(w);
    w.marker = MarkStart - 8'd1;
    queue_word(w);
    w = make_word(WkGood, 1);
    w.source_id = 8'd0;
    queue_word(w);
    w.source_id = 8'(NSRC + 1);
    queue_word(w);
    w.source_id = 8'hff;
    queue_word(w);
    w = make_word(WkGood, 2);
    w.random_value = '1;
    queue_word(w);
    queue_word(make_word(WkGood, 2));
    w = make_word(WkGood, 3);
    w.seed_value = '0;
    queue_word(w);
    queue_word(make_word(WkGood, 3));
    w = make_word(WkGood, 4);
    w.sequence_number = w.sequence_number + 32'd5;
    queue_word(w);
    w = make_word(WkGood, 4);
    w.sequence_number = w.sequence_number - 32'd1;
    queue_word(w);
    w = make_word(WkGood, 4);
    w.sequence_number = '1;
    queue_word(w);
    // count wraps to zero here
    queue_word(make_word(WkGood, 4));
    repeat (3) queue_word(make_word(WkGood, 1));
    drain(20000);

    write_reg(RegLcgMode, 32'hffff_ffff);
    write_reg(RegInitialSeed, 32'hffff_ffff);
    run_phase(100, 0, 0);
    write_reg(RegInitialSeed, 32'h0000_0000);
    run_phase(100, 40, 50);
    // mode change alone keeps the per-source state
    write_reg(RegLcgMode, 32'hffff_fffe);
    run_phase(100, 20, 70);
    write_reg(RegInitialSeed, $urandom());
    run_phase(100, 60, 30);

    drain(20000);
    repeat (8) @(posedge clk_i);
    if (verdict_q.size() != 0) begin
      errors += verdict_q.size();
      $display("%0d results never arrived", verdict_q.size());
    end
    $display("checked %0d result words over %0d register settings, %0d errors",
             n_results, n_settings, errors);
    $display("ok %0d, bad random %0d, bad seed %0d, missing %0d, bad source %0d, bad marker %0d",
             status_seen[StOk], status_seen[StBadRandom], status_seen[StBadSeed],
             status_seen[StMissing], status_seen[StBadSource], status_seen[StBadMarker]);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("timeout: run did not complete");
    $display("== FAIL ==");
    $finish;
  end

endmodule

[sim.f]
rtl/core/psc_pkg.sv
rtl/core/psc_ram.sv
rtl/core/psc_check.sv
rtl/core/prng_stream_checker.sv
tb/tb_top.sv
